// ----- rtl/e2q_pkg.sv -----
// Shared types and constants for the Euler-angle to quaternion core.
package e2q_pkg;

    // Working width of the CORDIC datapath and of rounded products (Q.30 with headroom)
    localparam int WORK_W    = 34;
    localparam int WORK_FRAC = 30;
    localparam int PROD_W    = 2 * WORK_W;
    localparam int FIELD_W   = 16;
    localparam int LANES     = 3;

    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // CORDIC start value: 1/gain in Q4.30
    localparam work_t CORDIC_GAIN_INIT = 34'sh026DD3B6A;

    // Arctangent of 2^-i, 2^32 units per turn, truncated
    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

endpackage

// ----- rtl/euler_to_quaternion_core.sv -----
// Pipelined Euler-angle to unit-quaternion converter with CORDIC and product chain.
//
//  Channel | Dir | tdata fields (low bit up)                    | Width
//  s_      | in  | angle_x, angle_y, angle_z                    | 48
//  m_      | out | quat_i, quat_j, quat_k, quat_real            | 64
//
// One request per cycle while the output is not stalled; the pipeline holds one register
// per CORDIC stage plus input, two multiply, two rounding and output registers.
// aresetn (synchronous, active low) clears all valid bits; payload is not reset.
// When the output holds an untaken result the whole pipeline freezes and
// s_tready drops; nothing is lost or repeated.
module euler_to_quaternion_core #(
    parameter int ANGLE_BITS    = 16,
    parameter int FRAC_BITS     = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // angle_x [15:0], angle_y [31:16], angle_z [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // quat_i, quat_j, quat_k, quat_real, 16 bits each
);

    localparam int N      = CORDIC_STAGES;
    localparam int W      = e2q_pkg::WORK_W;
    localparam int LAST   = N + 5;
    localparam int DROP   = e2q_pkg::WORK_FRAC - FRAC_BITS;
    localparam int SUM_W  = W + 2;

    logic ce;
    logic vld_reg [0:LAST];

    // CORDIC lanes: stage 0 is the input register
    e2q_pkg::work_t x_reg [0:N][0:e2q_pkg::LANES-1];
    e2q_pkg::work_t y_reg [0:N][0:e2q_pkg::LANES-1];
    e2q_pkg::work_t z_reg [0:N][0:e2q_pkg::LANES-1];

    // Advance whenever the output register is free or being taken
    assign ce       = !vld_reg[LAST] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAST];

    // Move valid bits down the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LAST; i++) vld_reg[i] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= LAST; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Load half-angle phases from the request
    genvar l, st;
    generate
        for (l = 0; l < e2q_pkg::LANES; l++) begin : g_in
            logic [31:0]                  raw32;
            logic signed [ANGLE_BITS-1:0] ang;
            e2q_pkg::work_t               v;
            e2q_pkg::work_t               z_next;
            assign raw32 = {16'b0, s_tdata[16*l +: 16]};
            assign ang   = raw32[ANGLE_BITS-1:0];
            assign v     = W'(ang);
            if (ANGLE_BITS < 32) begin : g_shl
                assign z_next = v <<< (31 - ANGLE_BITS);
            end else begin : g_shr
                assign z_next = v >>> 1;
            end
            always_ff @(posedge aclk) begin
                if (ce) begin
                    x_reg[0][l] <= e2q_pkg::CORDIC_GAIN_INIT;
                    y_reg[0][l] <= '0;
                    z_reg[0][l] <= z_next;
                end
            end
        end

        // One micro-rotation per stage and lane
        for (st = 0; st < N; st++) begin : g_cordic
            for (l = 0; l < e2q_pkg::LANES; l++) begin : g_lane
                e2q_pkg::work_t dx, dy, at;
                logic           pos;
                assign dx  = y_reg[st][l] >>> st;
                assign dy  = x_reg[st][l] >>> st;
                assign at  = W'(e2q_pkg::ATAN_TURNS[st]);
                assign pos = !z_reg[st][l][W-1];
                always_ff @(posedge aclk) begin
                    if (ce) begin
                        x_reg[st+1][l] <= pos ? x_reg[st][l] - dx : x_reg[st][l] + dx;
                        y_reg[st+1][l] <= pos ? y_reg[st][l] + dy : y_reg[st][l] - dy;
                        z_reg[st+1][l] <= pos ? z_reg[st][l] - at : z_reg[st][l] + at;
                    end
                end
            end
        end
    endgenerate

    function automatic e2q_pkg::work_t round_q30(e2q_pkg::prod_t p);
        e2q_pkg::prod_t t;
        t = (p + (e2q_pkg::prod_t'(1) <<< (e2q_pkg::WORK_FRAC - 1))) >>> e2q_pkg::WORK_FRAC;
        return t[W-1:0];
    endfunction

    e2q_pkg::work_t cx, sx, cy, sy, cz, sz;
    assign cx = x_reg[N][0];
    assign sx = y_reg[N][0];
    assign cy = x_reg[N][1];
    assign sy = y_reg[N][1];
    assign cz = x_reg[N][2];
    assign sz = y_reg[N][2];

    // First products: pairs of x and y terms; z terms ride along
    e2q_pkg::prod_t p_sxcy_reg, p_cxsy_reg, p_cxcy_reg, p_sxsy_reg;
    e2q_pkg::work_t cz1_reg, sz1_reg, cz2_reg, sz2_reg;
    e2q_pkg::work_t r_sxcy_reg, r_cxsy_reg, r_cxcy_reg, r_sxsy_reg;
    e2q_pkg::prod_t t_reg [0:7];
    e2q_pkg::work_t u_reg [0:7];
    logic [15:0]    q_reg [0:3];

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_sxcy_reg <= e2q_pkg::PROD_W'(sx) * e2q_pkg::PROD_W'(cy);
            p_cxsy_reg <= e2q_pkg::PROD_W'(cx) * e2q_pkg::PROD_W'(sy);
            p_cxcy_reg <= e2q_pkg::PROD_W'(cx) * e2q_pkg::PROD_W'(cy);
            p_sxsy_reg <= e2q_pkg::PROD_W'(sx) * e2q_pkg::PROD_W'(sy);
            cz1_reg    <= cz;
            sz1_reg    <= sz;
            // Round pair products back to Q4.30
            r_sxcy_reg <= round_q30(p_sxcy_reg);
            r_cxsy_reg <= round_q30(p_cxsy_reg);
            r_cxcy_reg <= round_q30(p_cxcy_reg);
            r_sxsy_reg <= round_q30(p_sxsy_reg);
            cz2_reg    <= cz1_reg;
            sz2_reg    <= sz1_reg;
            // Triple products
            t_reg[0] <= e2q_pkg::PROD_W'(r_sxcy_reg) * e2q_pkg::PROD_W'(cz2_reg);
            t_reg[1] <= e2q_pkg::PROD_W'(r_cxsy_reg) * e2q_pkg::PROD_W'(sz2_reg);
            t_reg[2] <= e2q_pkg::PROD_W'(r_cxsy_reg) * e2q_pkg::PROD_W'(cz2_reg);
            t_reg[3] <= e2q_pkg::PROD_W'(r_sxcy_reg) * e2q_pkg::PROD_W'(sz2_reg);
            t_reg[4] <= e2q_pkg::PROD_W'(r_cxcy_reg) * e2q_pkg::PROD_W'(sz2_reg);
            t_reg[5] <= e2q_pkg::PROD_W'(r_sxsy_reg) * e2q_pkg::PROD_W'(cz2_reg);
            t_reg[6] <= e2q_pkg::PROD_W'(r_cxcy_reg) * e2q_pkg::PROD_W'(cz2_reg);
            t_reg[7] <= e2q_pkg::PROD_W'(r_sxsy_reg) * e2q_pkg::PROD_W'(sz2_reg);
            for (int k = 0; k < 8; k++) u_reg[k] <= round_q30(t_reg[k]);
        end
    end

    // Combine, round to output precision and clamp to +/-1.0
    function automatic logic [15:0] finish(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] one;
        one = SUM_W'(1) <<< FRAC_BITS;
        if (DROP == 0) r = v;
        else r = (v + (SUM_W'(1) <<< (DROP - 1))) >>> DROP;
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r[15:0];
    endfunction

    logic signed [SUM_W-1:0] sum_next [0:3];
    always_comb begin
        sum_next[0] = SUM_W'(u_reg[0]) - SUM_W'(u_reg[1]);
        sum_next[1] = SUM_W'(u_reg[2]) + SUM_W'(u_reg[3]);
        sum_next[2] = SUM_W'(u_reg[4]) - SUM_W'(u_reg[5]);
        sum_next[3] = SUM_W'(u_reg[6]) + SUM_W'(u_reg[7]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 4; k++) q_reg[k] <= finish(sum_next[k]);
        end
    end

    assign m_tdata = {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};

endmodule

// ----- rtl/e2q_checker.sv -----
// Port-level checker for the Euler-angle to quaternion core, with its bind.
module e2q_checker #(
    parameter int FRAC_BITS = 14
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    localparam logic signed [15:0] ONE = 16'sd16384;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Stalled result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input is taken exactly when the output stage can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // Components stay within +/-1.0 (checked only when FRAC_BITS is 14)
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && FRAC_BITS == 14 |->
            ($signed(m_tdata[15:0])  <= ONE) && ($signed(m_tdata[15:0])  >= -ONE) &&
            ($signed(m_tdata[31:16]) <= ONE) && ($signed(m_tdata[31:16]) >= -ONE) &&
            ($signed(m_tdata[47:32]) <= ONE) && ($signed(m_tdata[47:32]) >= -ONE) &&
            ($signed(m_tdata[63:48]) <= ONE) && ($signed(m_tdata[63:48]) >= -ONE))
        else $error("quaternion component out of range");

endmodule

bind euler_to_quaternion_core e2q_checker #(.FRAC_BITS(FRAC_BITS)) u_e2q_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
